/* design/assert_macros.svh */
// assertion macros shared by the sparse coo adder rtl
// no dependencies; simulation forms are dropped when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define SCMA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define SCMA_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define SCMA_ASSERT(lbl, clk, rstn, prop, msg)
`define SCMA_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* design/scma_pkg.sv */
// package for the sparse coo matrix adder: function codes and result type
// no dependencies
package scma_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_END    = 2'd2
  } func_e;

  // one merged result as it leaves the merge engine
  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] value;
    logic        last;
    logic        empty;
    logic        overflow;
  } res_t;

endpackage

/* design/scma_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module scma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/scma_merge.sv */
// two pointer merge engine: reads both list rams and emits one result a cycle
// depends on scma_pkg and assert_macros.svh
`include "assert_macros.svh"

module scma_merge #(
  parameter int CB         = 16,
  parameter int CW         = 6,
  parameter int AW         = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [CW-1:0]        n_a_i,
  input  logic [CW-1:0]        n_b_i,
  input  logic                 dropped_i,
  output logic                 rd_en_a_o,
  output logic [AW-1:0]        rd_addr_a_o,
  input  logic [2*CB+31:0]     rd_data_a_i,
  output logic                 rd_en_b_o,
  output logic [AW-1:0]        rd_addr_b_o,
  input  logic [2*CB+31:0]     rd_data_b_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 res_valid_o,
  output scma_pkg::res_t       res_o
);
  import scma_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  i_q, i_d, j_q, j_d;
  logic           res_valid_q, res_valid_d;
  res_t           res_q, res_d;

  logic [CB-1:0]  row_a, col_a, row_b, col_b;
  logic [31:0]    val_a, val_b;
  logic           have_a, have_b;
  logic [2*CB-1:0] key_a, key_b;
  logic [CB-1:0]  pick_row, pick_col;
  logic [31:0]    pick_val;
  logic           nonempty;

  // unpack the entries read last cycle
  assign row_a = rd_data_a_i[CB-1:0];
  assign col_a = rd_data_a_i[2*CB-1:CB];
  assign val_a = rd_data_a_i[2*CB+31:2*CB];
  assign row_b = rd_data_b_i[CB-1:0];
  assign col_b = rd_data_b_i[2*CB-1:CB];
  assign val_b = rd_data_b_i[2*CB+31:2*CB];
  assign key_a = {row_a, col_a};
  assign key_b = {row_b, col_b};
  assign have_a = i_q < n_a_i;
  assign have_b = j_q < n_b_i;
  assign nonempty = (n_a_i != '0) || (n_b_i != '0);

  // pick the next entry, advance pointers, build the result
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    done_o      = 1'b0;
    pick_row    = row_b;
    pick_col    = col_b;
    pick_val    = val_b;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          i_d = '0;
          j_d = '0;
          if (nonempty) begin
            state_d = ST_RUN;
          end else begin
            // both lists empty: a single flagged result
            res_valid_d    = 1'b1;
            res_d.row      = '0;
            res_d.col      = '0;
            res_d.value    = '0;
            res_d.last     = 1'b1;
            res_d.empty    = 1'b1;
            res_d.overflow = dropped_i;
            done_o         = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (have_a && have_b) begin
          if (key_a < key_b) begin
            pick_row = row_a;
            pick_col = col_a;
            pick_val = val_a;
            i_d      = i_q + CW'(1);
          end else if (key_a > key_b) begin
            j_d = j_q + CW'(1);
          end else begin
            // same position: sum wraps at 32 bits
            pick_val = val_a + val_b;
            i_d      = i_q + CW'(1);
            j_d      = j_q + CW'(1);
          end
        end else if (have_a) begin
          pick_row = row_a;
          pick_col = col_a;
          pick_val = val_a;
          i_d      = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        res_valid_d    = 1'b1;
        res_d.row      = 16'(pick_row);
        res_d.col      = 16'(pick_col);
        res_d.value    = pick_val;
        res_d.last     = (i_d >= n_a_i) && (j_d >= n_b_i);
        res_d.empty    = 1'b0;
        res_d.overflow = dropped_i;
        if (res_d.last) begin
          state_d = ST_IDLE;
          done_o  = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // read the entries under the next pointers
  assign rd_en_a_o   = ((state_q == ST_IDLE && go_i) || state_q == ST_RUN) && (i_d < n_a_i);
  assign rd_en_b_o   = ((state_q == ST_IDLE && go_i) || state_q == ST_RUN) && (j_d < n_b_i);
  assign rd_addr_a_o = i_d[AW-1:0];
  assign rd_addr_b_o = j_d[AW-1:0];

  // state, pointers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `SCMA_ASSERT(a_run_has_work, clk_i, rst_ni, (state_q == ST_RUN) |-> (have_a || have_b), "merge running with both lists exhausted")
  `SCMA_ASSERT(a_ptr_bound, clk_i, rst_ni, (state_q == ST_RUN) |-> ((i_q <= n_a_i) && (j_q <= n_b_i)), "merge pointer beyond list count")
  `SCMA_ASSERT(a_empty_is_last, clk_i, rst_ni, (res_valid_q && res_q.empty) |-> res_q.last, "empty result not marked last")

endmodule

/* design/sparse_coo_matrix_add_top.sv */
// top level of the sparse coo matrix adder: load counters, list rams, merge engine
// depends on scma_pkg, scma_ram, scma_merge and assert_macros.svh
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------------------------
//  input    | start_i, busy_o             | func_i, row_index_i, col_index_i, entry_value_i
//  result   | out_valid_o (one cycle)     | out_row_o, out_col_o, out_value_o,
//           |                             | last_entry_o, empty_result_o, overflow_flag_o
//
// load items give no result; func code 3 is ignored.
// an end item holds busy_o high while the merge runs, the first ram read
// overlapping the accepting cycle; results follow one per cycle, each in the
// cycle after it is picked. with both lists empty the single flagged result
// comes in the cycle after the end item and busy stays low.
// reset clears counts and the overflow flag; the list rams need no clearing.
// the receiver cannot stall: results are strobed and never held.
`include "assert_macros.svh"

module sparse_coo_matrix_add_top #(
  parameter int LIST_DEPTH = 32,
  parameter int COORD_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        row_index_i,
  input  logic [15:0]        col_index_i,
  input  logic signed [31:0] entry_value_i,
  output logic               out_valid_o,
  output logic [15:0]        out_row_o,
  output logic [15:0]        out_col_o,
  output logic signed [31:0] out_value_o,
  output logic               last_entry_o,
  output logic               empty_result_o,
  output logic               overflow_flag_o
);
  import scma_pkg::*;

  localparam int CB = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int DW = 2 * CB + 32;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          dropped_q, dropped_d;
  logic          accept, go, done;
  logic          we_a, we_b;
  logic [DW-1:0] wdata;
  logic          re_a, re_b;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [DW-1:0] rdata_a, rdata_b;
  res_t          res;
  logic          res_valid;

  assign accept = start_i && !busy_o;
  assign go     = accept && (func_i == FUNC_END);
  assign wdata  = {entry_value_i, col_index_i[CB-1:0], row_index_i[CB-1:0]};

  // append loads to their list, drop and flag when full; clear counts and flag when a merge is done
  always_comb begin
    cnt_a_d   = cnt_a_q;
    cnt_b_d   = cnt_b_q;
    dropped_d = dropped_q;
    we_a      = 1'b0;
    we_b      = 1'b0;
    if (done) begin
      cnt_a_d   = '0;
      cnt_b_d   = '0;
      dropped_d = 1'b0;
    end else if (accept && func_i == FUNC_LOAD_A) begin
      if (cnt_a_q < CW'(LIST_DEPTH)) begin
        we_a    = 1'b1;
        cnt_a_d = cnt_a_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end else if (accept && func_i == FUNC_LOAD_B) begin
      if (cnt_b_q < CW'(LIST_DEPTH)) begin
        we_b    = 1'b1;
        cnt_b_d = cnt_b_q + CW'(1);
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      dropped_q <= dropped_d;
    end
  end

  // list stores: written only while idle, read only while merging or as an end item is accepted
  scma_ram #(
    .WIDTH (DW),
    .DEPTH (LIST_DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re_a),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  scma_ram #(
    .WIDTH (DW),
    .DEPTH (LIST_DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (re_b),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // merge engine
  scma_merge #(
    .CB         (CB),
    .CW         (CW),
    .AW         (AW)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .n_a_i       (cnt_a_q),
    .n_b_i       (cnt_b_q),
    .dropped_i   (dropped_q),
    .rd_en_a_o   (re_a),
    .rd_addr_a_o (raddr_a),
    .rd_data_a_i (rdata_a),
    .rd_en_b_o   (re_b),
    .rd_addr_b_o (raddr_b),
    .rd_data_b_i (rdata_b),
    .busy_o      (busy_o),
    .done_o      (done),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result ports
  assign out_valid_o     = res_valid;
  assign out_row_o       = res.row;
  assign out_col_o       = res.col;
  assign out_value_o     = res.value;
  assign last_entry_o    = res.last;
  assign empty_result_o  = res.empty;
  assign overflow_flag_o = res.overflow;

  `SCMA_NEVER(a_no_write_busy, clk_i, rst_ni, (we_a || we_b) && busy_o, "list written during merge")
  `SCMA_ASSERT(a_go_busy, clk_i, rst_ni, (go && (cnt_a_q != '0 || cnt_b_q != '0)) |=> busy_o, "merge did not start")
  `SCMA_ASSERT(a_done_clears, clk_i, rst_ni, done |=> (cnt_a_q == '0 && cnt_b_q == '0 && !dropped_q), "lists not cleared after merge")

endmodule
